// File: design/lrwd_pkg.sv
// lrwd_pkg: shared types, codes and helpers for the least remaining work dispatcher
// depends on nothing; imported by the dispatcher top level
`default_nettype none

package lrwd_pkg;

    localparam int DAY_W    = 32;
    localparam int JOB_W    = 16;
    localparam int DUR_W    = 16;
    localparam int WORKER_W = 5;
    localparam int CFG_W    = 5;

    typedef logic [DAY_W-1:0]    day_t;
    typedef logic [JOB_W-1:0]    job_t;
    typedef logic [DUR_W-1:0]    dur_t;
    typedef logic [WORKER_W-1:0] worker_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    // opcodes of an input transaction
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // kinds of an output transaction
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_TOTAL  = 1'b1;

    localparam cfg_t CFG_RESET = 5'd16;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPDATE,
        ST_UPDATE_END,
        ST_DONE
    } lrwd_state_t;

    // saturating day advance
    function automatic day_t day_add(input day_t a, input dur_t b);
        logic [DAY_W:0] s;
        s = {1'b0, a} + {{(DAY_W - DUR_W + 1){1'b0}}, b};
        return s[DAY_W] ? {DAY_W{1'b1}} : s[DAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/lrwd_ram.sv
// lrwd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lrwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/least_remaining_work_dispatcher_top.sv
// a submit scans the active workers in order and stops at the first idle one; with all n
// workers busy it scans all n, then updates all MAX_WORKERS entries of the work memory;
// a finish scans all MAX_WORKERS entries. the sequencer returns to idle, ready for the
// next transaction, as the result loads. a scan reads the work memory once per cycle.
// reset clears busy bits, day counter and sequencer and sets the worker count to 16;
// memory contents are not cleared, an entry only counts once its busy bit is set.
// depends on lrwd_pkg and lrwd_ram
`default_nettype none

module least_remaining_work_dispatcher_top #(
    parameter int MAX_WORKERS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_we,
    input  wire lrwd_pkg::cfg_t    cfg_wdata,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_opcode,
    input  wire lrwd_pkg::job_t    s_job_id,
    input  wire lrwd_pkg::dur_t    s_job_duration,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_result_kind,
    output lrwd_pkg::job_t         m_assigned_job,
    output lrwd_pkg::worker_t      m_assigned_worker,
    output lrwd_pkg::day_t         m_day
);

    import lrwd_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WORKERS - 1);

    lrwd_state_t            state_reg, state_next;
    cfg_t                   worker_count_reg;
    logic                   op_reg, op_next;
    job_t                   job_reg, job_next;
    dur_t                   dur_reg, dur_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    dur_t                   least_reg, least_next;
    dur_t                   most_reg, most_next;
    logic                   idle_found_reg, idle_found_next;
    logic [MAX_WORKERS-1:0] busy_reg, busy_next;
    day_t                   current_day_reg, current_day_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_kind_reg, m_kind_next;
    job_t                   m_job_reg, m_job_next;
    worker_t                m_worker_reg, m_worker_next;
    day_t                   m_day_reg, m_day_next;

    logic [CNT_W-1:0]       n_active;
    logic [IDX_W-1:0]       scan_last;
    logic                   idx_is_idle;
    logic                   at_last;
    logic                   upd_last;
    logic                   out_free;
    logic                   out_load;
    day_t                   day_adv;

    logic                   rd_en;
    dur_t                   rd_data;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    dur_t                   ram_wdata;

    // remaining work per worker
    lrwd_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_WORKERS)
    ) u_work_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    // workers in use, clamped to 1..MAX_WORKERS
    always_comb begin
        if (worker_count_reg == '0) begin
            n_active = CNT_W'(1);
        end else if (32'(worker_count_reg) > 32'(MAX_WORKERS)) begin
            n_active = CNT_W'(MAX_WORKERS);
        end else begin
            n_active = CNT_W'(worker_count_reg);
        end
    end

    assign scan_last   = (op_reg == OP_FINISH) ? IDX_LAST : IDX_W'(n_active - CNT_W'(1));
    assign idx_is_idle = !busy_reg[scan_idx_reg];
    assign at_last     = (scan_idx_reg == scan_last);
    assign upd_last    = (scan_idx_reg == IDX_LAST);
    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = (state_reg == ST_DONE) && out_free;
    assign day_adv     = day_add(current_day_reg, least_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (op_reg == OP_SUBMIT && idx_is_idle) begin
                    state_next = ST_DONE;
                end else if (at_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = (op_reg == OP_FINISH) ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE: begin
                if (upd_last) begin
                    state_next = ST_UPDATE_END;
                end
            end
            ST_UPDATE_END: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        op_next          = op_reg;
        job_next         = job_reg;
        dur_next         = dur_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = 1'b0;
        pend_idx_next    = scan_idx_reg;
        pick_next        = pick_reg;
        least_next       = least_reg;
        most_next        = most_reg;
        idle_found_next  = idle_found_reg;
        busy_next        = busy_reg;
        current_day_next = current_day_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_kind_next      = m_kind_reg;
        m_job_next       = m_job_reg;
        m_worker_next    = m_worker_reg;
        m_day_next       = m_day_reg;
        rd_en            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = pend_idx_reg;
        ram_wdata        = '0;

        // read data of the previous cycle
        if (pend_reg) begin
            if (state_reg == ST_SCAN || state_reg == ST_SCAN_END) begin
                if (op_reg == OP_FINISH) begin
                    if (busy_reg[pend_idx_reg] && rd_data > most_reg) begin
                        most_next = rd_data;
                    end
                end else if (pend_idx_reg == '0 || rd_data < least_reg) begin
                    least_next = rd_data;
                    pick_next  = pend_idx_reg;
                end
            end else if (state_reg == ST_UPDATE || state_reg == ST_UPDATE_END) begin
                ram_we = busy_reg[pend_idx_reg];
                if (pend_idx_reg == pick_reg) begin
                    ram_wdata = dur_reg;
                end else begin
                    ram_wdata = (rd_data > least_reg) ? dur_t'(rd_data - least_reg) : '0;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    job_next        = s_job_id;
                    dur_next        = s_job_duration;
                    scan_idx_next   = '0;
                    idle_found_next = 1'b0;
                    most_next       = '0;
                    least_next      = '0;
                end
            end
            ST_SCAN: begin
                if (op_reg == OP_SUBMIT && idx_is_idle) begin
                    idle_found_next = 1'b1;
                    pick_next       = scan_idx_reg;
                end else begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    if (!at_last) begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_SCAN_END: begin
                scan_idx_next = '0;
            end
            ST_UPDATE: begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (!upd_last) begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_UPDATE_END: begin
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (op_reg == OP_FINISH) begin
                        m_kind_next      = KIND_TOTAL;
                        m_job_next       = '0;
                        m_worker_next    = '0;
                        m_day_next       = day_add(current_day_reg, most_reg);
                        busy_next        = '0;
                        current_day_next = '0;
                    end else begin
                        m_kind_next   = KIND_ASSIGN;
                        m_job_next    = job_reg;
                        m_worker_next = worker_t'({1'b0, pick_reg} + (IDX_W + 1)'(1));
                        busy_next[pick_reg] = 1'b1;
                        if (idle_found_reg) begin
                            ram_we     = 1'b1;
                            ram_waddr  = pick_reg;
                            ram_wdata  = dur_reg;
                            m_day_next = current_day_reg;
                        end else begin
                            current_day_next = day_adv;
                            m_day_next       = day_adv;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            worker_count_reg <= CFG_RESET;
            pend_reg         <= 1'b0;
            busy_reg         <= '0;
            current_day_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            busy_reg        <= busy_next;
            current_day_reg <= current_day_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                worker_count_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        job_reg        <= job_next;
        dur_reg        <= dur_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pick_reg       <= pick_next;
        least_reg      <= least_next;
        most_reg       <= most_next;
        idle_found_reg <= idle_found_next;
        m_kind_reg     <= m_kind_next;
        m_job_reg      <= m_job_next;
        m_worker_reg   <= m_worker_next;
        m_day_reg      <= m_day_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_result_kind     = m_kind_reg;
    assign m_assigned_job    = m_job_reg;
    assign m_assigned_worker = m_worker_reg;
    assign m_day             = m_day_reg;

    // write-back never hits the entry being read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && rd_en) |-> (ram_waddr != scan_idx_reg))
        else $error("work memory write and read collide");

    // a finish transaction leaves the pool empty and the day at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && op_reg == OP_FINISH) |=> (busy_reg == '0 && current_day_reg == '0))
        else $error("pool not cleared after finish");

    // the chosen worker is busy after an assignment
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && op_reg == OP_SUBMIT) |=> busy_reg[$past(pick_reg)])
        else $error("assigned worker not marked busy");

    // the day never moves backward within a batch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && op_reg == OP_SUBMIT) |=> (current_day_reg >= $past(current_day_reg)))
        else $error("day counter went backward");

endmodule

`default_nettype wire
